// ----- hdl/rc_stick_trim_processor_macros.svh -----
// assertion macros for the stick and trim processor checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef RC_STICK_TRIM_PROCESSOR_MACROS_SVH
`define RC_STICK_TRIM_PROCESSOR_MACROS_SVH

// same-cycle implication, off while in reset
`define RCST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define RCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define RCST_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rcst_pkg.sv -----
// shared types and constants of the stick and trim processor
// no dependencies
package rcst_pkg;

  localparam int ADC_W = 12;

  localparam logic [10:0] CH_MIN = 11'd1000;
  localparam logic [10:0] CH_MAX = 11'd2000;

  localparam logic signed [8:0] TRIM_LIMIT = 9'sd250;
  localparam logic signed [8:0] TRIM_STEP  = 9'sd5;

  // floor(n/5) = (n * 52429) >> 18 for n below 2^16
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_LOW  = 2'd1;
  localparam logic [1:0] BEEP_HIGH = 2'd2;

  localparam logic [1:0] SAVED_NONE  = 2'd0;
  localparam logic [1:0] SAVED_ROLL  = 2'd1;
  localparam logic [1:0] SAVED_PITCH = 2'd2;

  typedef enum logic [1:0] {
    CFG_ROLL_TRIM_START  = 2'd0,
    CFG_PITCH_TRIM_START = 2'd1,
    CFG_PRESS_DELAY      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       en;
    logic [1:0] index;
    logic [8:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]        beep;
    logic [1:0]        saved;
    logic [3:0]        aux_high;
    logic signed [8:0] roll_trim_now;
    logic signed [8:0] pitch_trim_now;
  } btn_status_t;

  localparam int OUT_W = 112;

endpackage

// ----- hdl/rc_stick_trim_processor.sv -----
// top level of the stick and trim processor
// depends on rcst_pkg, rcst_lane, rcst_btn and rcst_out
//
// channel | dir | handshake             | content
// --------+-----+-----------------------+---------------------------------------
// in_     | in  | in_tvalid / in_tready | one tick: four stick samples, buttons,
//         |     |                       | time stamp
// out_    | out | out_tvalid/out_tready | one result per tick: channels, aux,
//         |     |                       | beep, trim flags and trims
// cfg_    | in  | cfg_valid / cfg_ready | register writes, index and data
//
// one request per clock while in_tready is high; its result is registered into the output buffer on acceptance
// each stick lane updates its smoothing state in the accept cycle, so back to
// back requests flow with no gap
// a two-entry output buffer absorbs stalls: in_tready drops only when both
// entries hold results not yet taken
// rst_n is synchronous, active low; a reset clears all control state, with
// trims at zero and the press delay at 30 ticks
// cfg_ready is always high; writes take effect on the next cycle
module rc_stick_trim_processor #(
  parameter int ADC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  // request fields from bit 0 up: adc_yaw[11:0], adc_throttle[11:0],
  // adc_pitch[11:0], adc_roll[11:0], buttons[7:0], tick_time[31:0]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,
  // result fields from bit 0 up: throttle_out[10:0], pitch_out[10:0],
  // yaw_out[10:0], roll_out[10:0], aux_one[10:0], aux_two[10:0],
  // aux_three[10:0], aux_four[10:0], beep[1:0], trim_saved[1:0],
  // roll_trim_now[8:0], pitch_trim_now[8:0], two zero pad bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,
  // register writes: 0 roll_trim_start, 1 pitch_trim_start, 2 press_delay
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int AW = rcst_pkg::ADC_W;

  logic                  in_accept;
  logic [AW-1:0]         adc_yaw, adc_throttle, adc_pitch, adc_roll;
  logic [7:0]            buttons;
  logic [31:0]           tick_time;
  logic signed [8:0]     roll_trim, pitch_trim;
  logic [10:0]           ch_thr, ch_pit, ch_yaw, ch_rol;
  rcst_pkg::btn_status_t status;
  rcst_pkg::cfg_wr_t     cfg;

  assign in_accept = in_tvalid && in_tready;

  // unpack the request
  assign adc_yaw      = in_tdata[11:0];
  assign adc_throttle = in_tdata[23:12];
  assign adc_pitch    = in_tdata[35:24];
  assign adc_roll     = in_tdata[47:36];
  assign buttons      = in_tdata[55:48];
  assign tick_time    = in_tdata[87:56];

  // config port never stalls
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // four stick lanes side by side; throttle scales by 1/5, the rest by 1/4
  rcst_lane #(.ADC_BITS(ADC_BITS), .DIV_BY_FIVE(1'b1)) u_lane_thr (
    .clk(clk), .rst_n(rst_n), .en(in_accept),
    .sample(adc_throttle), .trim(9'sd0), .ch_out(ch_thr)
  );

  rcst_lane #(.ADC_BITS(ADC_BITS), .DIV_BY_FIVE(1'b0)) u_lane_pit (
    .clk(clk), .rst_n(rst_n), .en(in_accept),
    .sample(adc_pitch), .trim(pitch_trim), .ch_out(ch_pit)
  );

  // yaw carries no trim
  rcst_lane #(.ADC_BITS(ADC_BITS), .DIV_BY_FIVE(1'b0)) u_lane_yaw (
    .clk(clk), .rst_n(rst_n), .en(in_accept),
    .sample(adc_yaw), .trim(9'sd0), .ch_out(ch_yaw)
  );

  rcst_lane #(.ADC_BITS(ADC_BITS), .DIV_BY_FIVE(1'b0)) u_lane_rol (
    .clk(clk), .rst_n(rst_n), .en(in_accept),
    .sample(adc_roll), .trim(roll_trim), .ch_out(ch_rol)
  );

  // button sequencer; lanes see the trims from before this tick's action
  rcst_btn u_btn (
    .clk(clk), .rst_n(rst_n), .accept(in_accept),
    .buttons(buttons), .tick_time(tick_time), .cfg(cfg),
    .roll_trim(roll_trim), .pitch_trim(pitch_trim), .status(status)
  );

  // merge lane results and button status into the output buffer
  rcst_out u_out (
    .clk(clk), .rst_n(rst_n), .push(in_accept),
    .ch_thr(ch_thr), .ch_pit(ch_pit), .ch_yaw(ch_yaw), .ch_rol(ch_rol),
    .status(status), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .out_tdata(out_tdata), .in_ready(in_tready)
  );

endmodule

// ----- hdl/rcst_lane.sv -----
// one stick channel lane: scaling, trim, smoothing and clamp
// depends on rcst_pkg
module rcst_lane #(
  parameter int ADC_BITS    = 12,
  parameter bit DIV_BY_FIVE = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [rcst_pkg::ADC_W-1:0]     sample,
  input  logic signed [8:0]              trim,
  output logic [10:0]                    ch_out
);

  localparam int AW       = rcst_pkg::ADC_W;
  localparam int SAMPLE_W = (ADC_BITS < AW) ? ADC_BITS : AW;
  localparam logic [31:0] MASK_FULL = (32'd1 << SAMPLE_W) - 32'd1;
  localparam int PROD_W   = AW + 16;
  localparam int Q_W      = AW - 2;
  localparam int X_W      = AW + 1;
  localparam int ACC_W    = AW + 2;

  logic [AW-1:0]     s;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  logic [X_W-1:0]    x;
  logic [ACC_W-1:0]  acc;
  logic [AW-1:0]     v;
  logic [AW-1:0]     prev_r;
  logic [AW-1:0]     prev_nxt;

  assign s    = sample & MASK_FULL[AW-1:0];
  assign prod = {{16{1'b0}}, s} * {{AW{1'b0}}, rcst_pkg::DIV5_RECIP};
  assign q    = DIV_BY_FIVE ? prod[PROD_W-1:rcst_pkg::DIV5_SHIFT] : s[AW-1:2];

  // base plus scaled sample plus signed trim, never negative
  assign x = {{(X_W-11){1'b0}}, rcst_pkg::CH_MIN} + {{(X_W-Q_W){1'b0}}, q}
           + {{(X_W-9){trim[8]}}, trim};

  // floor((x + 3*prev) / 4)
  assign acc = {2'b00, x[AW-1:0]} + {2'b00, prev_r} + {1'b0, prev_r, 1'b0};
  assign v   = acc[ACC_W-1:2];

  assign prev_nxt = en ? v : prev_r;

  always_comb begin
    if (v > {{(AW-11){1'b0}}, rcst_pkg::CH_MAX}) begin
      ch_out = rcst_pkg::CH_MAX;
    end else if (v < {{(AW-11){1'b0}}, rcst_pkg::CH_MIN}) begin
      ch_out = rcst_pkg::CH_MIN;
    end else begin
      ch_out = v[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// ----- hdl/rcst_btn.sv -----
// button sequencer: rearm delay, aux toggles and trim steps
// depends on rcst_pkg
module rcst_btn (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            buttons,
  input  logic [31:0]           tick_time,
  input  rcst_pkg::cfg_wr_t     cfg,
  output logic signed [8:0]     roll_trim,
  output logic signed [8:0]     pitch_trim,
  output rcst_pkg::btn_status_t status
);

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_ARMED   = 2'd1,
    PH_PRESSED = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [31:0]       act_time_r, act_time_nxt;
  logic [3:0]        aux_r, aux_nxt;
  logic signed [8:0] roll_r, roll_nxt;
  logic signed [8:0] pitch_r, pitch_nxt;
  logic [7:0]        delay_r;
  logic [31:0]       elapsed;
  logic [1:0]        beep;
  logic [1:0]        saved;

  assign elapsed = tick_time - act_time_r;

  always_comb begin
    phase_nxt    = phase_r;
    act_time_nxt = act_time_r;
    aux_nxt      = aux_r;
    roll_nxt     = roll_r;
    pitch_nxt    = pitch_r;
    beep         = rcst_pkg::BEEP_NONE;
    saved        = rcst_pkg::SAVED_NONE;
    unique case (phase_r)
      PH_ARMED: begin
        if (buttons != 8'hFF) phase_nxt = PH_PRESSED;
      end
      PH_PRESSED: begin
        // the lowest-numbered pressed button wins; buttons are active low
        priority case (1'b0)
          buttons[0]: aux_nxt[0] = ~aux_r[0];
          buttons[1]: aux_nxt[1] = ~aux_r[1];
          buttons[2]: aux_nxt[2] = ~aux_r[2];
          buttons[3]: aux_nxt[3] = ~aux_r[3];
          buttons[4]: begin
            if (roll_r > -rcst_pkg::TRIM_LIMIT) begin
              roll_nxt = roll_r - rcst_pkg::TRIM_STEP;
              saved    = rcst_pkg::SAVED_ROLL;
            end
          end
          buttons[5]: begin
            if (roll_r < rcst_pkg::TRIM_LIMIT) begin
              roll_nxt = roll_r + rcst_pkg::TRIM_STEP;
              saved    = rcst_pkg::SAVED_ROLL;
            end
          end
          buttons[6]: begin
            if (pitch_r > -rcst_pkg::TRIM_LIMIT) begin
              pitch_nxt = pitch_r - rcst_pkg::TRIM_STEP;
              saved     = rcst_pkg::SAVED_PITCH;
            end
          end
          buttons[7]: begin
            if (pitch_r < rcst_pkg::TRIM_LIMIT) begin
              pitch_nxt = pitch_r + rcst_pkg::TRIM_STEP;
              saved     = rcst_pkg::SAVED_PITCH;
            end
          end
          default: ;
        endcase
        phase_nxt    = PH_WAIT;
        act_time_nxt = tick_time;
        beep         = rcst_pkg::BEEP_HIGH;
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (elapsed > {24'd0, delay_r}) begin
          if (buttons == 8'hFF) phase_nxt = PH_ARMED;
          beep = rcst_pkg::BEEP_LOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      act_time_r <= '0;
      aux_r      <= '0;
      roll_r     <= '0;
      pitch_r    <= '0;
      delay_r    <= 8'd30;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        act_time_r <= act_time_nxt;
        aux_r      <= aux_nxt;
        roll_r     <= roll_nxt;
        pitch_r    <= pitch_nxt;
      end
      if (cfg.en) begin
        unique case (cfg.index)
          rcst_pkg::CFG_ROLL_TRIM_START:  roll_r  <= cfg.data;
          rcst_pkg::CFG_PITCH_TRIM_START: pitch_r <= cfg.data;
          rcst_pkg::CFG_PRESS_DELAY:      delay_r <= cfg.data[7:0];
          default: ;
        endcase
      end
    end
  end

  assign roll_trim  = roll_r;
  assign pitch_trim = pitch_r;

  assign status.beep           = beep;
  assign status.saved          = saved;
  assign status.aux_high       = aux_nxt;
  assign status.roll_trim_now  = roll_nxt;
  assign status.pitch_trim_now = pitch_nxt;

endmodule

// ----- hdl/rcst_out.sv -----
// merge stage: packs lane results and button status, two-deep output buffer
// depends on rcst_pkg
module rcst_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [10:0]                    ch_thr,
  input  logic [10:0]                    ch_pit,
  input  logic [10:0]                    ch_yaw,
  input  logic [10:0]                    ch_rol,
  input  rcst_pkg::btn_status_t          status,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [rcst_pkg::OUT_W-1:0]     out_tdata,
  output logic                           in_ready
);

  localparam int W = rcst_pkg::OUT_W;

  logic [W-1:0] packed_res;
  logic [10:0]  aux_val [4];
  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] main_r, main_nxt;
  logic [W-1:0] skid_r, skid_nxt;
  logic         take;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      aux_val[k] = status.aux_high[k] ? rcst_pkg::CH_MAX : rcst_pkg::CH_MIN;
    end
  end

  assign packed_res = {2'b00, status.pitch_trim_now, status.roll_trim_now,
                       status.saved, status.beep,
                       aux_val[3], aux_val[2], aux_val[1], aux_val[0],
                       ch_rol, ch_yaw, ch_pit, ch_thr};

  assign take = main_valid_r && out_tready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_nxt       = packed_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = packed_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = main_r;
  assign in_ready   = !skid_valid_r;

endmodule

// ----- hdl/rcst_checker.sv -----
// port-level checks of the stick and trim processor, bound to the top level
// depends on rc_stick_trim_processor_macros.svh
`include "rc_stick_trim_processor_macros.svh"

module rcst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [87:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [1:0]   cfg_index,
  input logic [8:0]   cfg_data
);

  `RCST_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")
  `RCST_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `RCST_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready && !out_tvalid, out_tvalid, "no result after request")
  `RCST_ASSERT_SAME(a_full_only, !in_tready, out_tvalid, "request stalled with empty output")

endmodule

bind rc_stick_trim_processor rcst_checker u_rcst_checker (.*);
